FILE: rtl/arpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the arp cache table
// Holds the bucket hash, tag layout, status codes and sequencer states.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // table geometry
    localparam int WAYS     = 4;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int BKT_W    = 8;
    localparam int TAG_AW   = BKT_W + WAY_W;
    localparam int TAG_DEPTH = 1 << TAG_AW;

    localparam int IP_W     = 32;
    localparam int MAC_W    = 48;
    localparam int OPC_W    = 16;

    // command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // arp operation code of a reply
    localparam logic [OPC_W-1:0] OP_REPLY = 16'd2;

    // result status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PENDING = 2'd1,
        ST_NOROOM  = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // one tag entry
    typedef struct packed {
        logic            resolved;
        logic            valid;
        logic [IP_W-1:0] ip;
    } tag_t;

    // tag memory write and read request
    typedef struct packed {
        logic              we;
        logic [TAG_AW-1:0] waddr;
        tag_t              wdata;
        logic [TAG_AW-1:0] raddr;
    } tag_req_t;

    // mac memory request
    typedef struct packed {
        logic              we;
        logic              re;
        logic [TAG_AW-1:0] addr;
        logic [MAC_W-1:0]  wdata;
    } mac_req_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CMP,
        S_UPDATE,
        S_DONE
    } state_t;

    // ip mod 255: 256 is 1 mod 255, so the byte sum keeps the residue
    function automatic logic [BKT_W-1:0] bucket_of(input logic [IP_W-1:0] ip);
        logic [9:0] sum;
        logic [8:0] fold;
        sum  = 10'(ip[7:0]) + 10'(ip[15:8]) + 10'(ip[23:16]) + 10'(ip[31:24]);
        fold = 9'(sum[9:8]) + 9'(sum[7:0]);
        if (fold >= 9'd255) begin
            fold = fold - 9'd255;
        end
        return fold[BKT_W-1:0];
    endfunction

endpackage
`default_nettype wire

FILE: rtl/arpc_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arpc_store: tag and mac memories of the arp cache table
// One write and one registered read port on each memory.
// ----------------------------------------------------------------------------
module arpc_store (
    input  wire logic              aclk,
    input  wire arpc_pkg::tag_req_t tag_req,
    output arpc_pkg::tag_t         tag_rdata,
    input  wire arpc_pkg::mac_req_t mac_req,
    output logic [arpc_pkg::MAC_W-1:0] mac_rdata
);

    arpc_pkg::tag_t              tag_mem [arpc_pkg::TAG_DEPTH];
    logic [arpc_pkg::MAC_W-1:0]  mac_mem [arpc_pkg::TAG_DEPTH];
    arpc_pkg::tag_t              tag_rd_reg;
    logic [arpc_pkg::MAC_W-1:0]  mac_rd_reg;

    // tag memory
    always_ff @(posedge aclk) begin
        if (tag_req.we) begin
            tag_mem[tag_req.waddr] <= tag_req.wdata;
        end
        tag_rd_reg <= tag_mem[tag_req.raddr];
    end

    // mac memory, read only when asked so the data holds
    always_ff @(posedge aclk) begin
        if (mac_req.we) begin
            mac_mem[mac_req.addr] <= mac_req.wdata;
        end
        if (mac_req.re) begin
            mac_rd_reg <= mac_mem[mac_req.addr];
        end
    end

    assign tag_rdata = tag_rd_reg;
    assign mac_rdata = mac_rd_reg;

endmodule
`default_nettype wire

FILE: rtl/arp_cache_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arp_cache_table_core: ip to mac address cache with request signalling
// Bucketed table of 255 buckets by ip mod 255, scanned one way at a time.
// ----------------------------------------------------------------------------
// After reset the block clears all TAG_DEPTH (1024) entries of its tag
// memory, one entry a cycle, with s_tready low. Each item then finds or
// allocates the entry of its ip in bucket ip mod 255. A single ip compare
// unit steps through the ways, one way per S_READ and S_CMP pass on the tag
// memory's registered read port, until a hit or the last of the WAYS ways.
// A packet whose opcode is not a reply goes from S_IDLE straight to S_DONE.
// One item is in work at a time; its result waits in an output register
// while the next item is taken.
// ----------------------------------------------------------------------------
module arp_cache_table_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // ip_addr[31:0], mac_in[79:32], arp_opcode[95:80]
    input  wire logic        s_tuser,   // command
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // mac_out[47:0], send_request[48],
                                        // request_target_ip[80:49], zero[87:81]
    output logic [1:0]       m_tuser    // status
);

    arpc_pkg::state_t state_reg, state_next;

    // item fields
    logic                          cmd_reg;
    logic [arpc_pkg::IP_W-1:0]     ip_reg;
    logic [arpc_pkg::MAC_W-1:0]    mac_in_reg;

    // scan state
    logic [arpc_pkg::BKT_W-1:0]    bucket_reg;
    logic [arpc_pkg::WAY_W-1:0]    way_reg;
    logic                          hit_reg;
    logic                          resolved_reg;
    logic [arpc_pkg::WAY_W-1:0]    hit_way_reg;
    logic                          free_found_reg;
    logic [arpc_pkg::WAY_W-1:0]    free_way_reg;
    logic [arpc_pkg::TAG_AW-1:0]   clr_cnt_reg;

    // pending result
    arpc_pkg::status_t             res_status_reg;
    logic                          res_mac_reg;

    // output register
    logic                          m_tvalid_reg;
    arpc_pkg::status_t             out_status_reg;
    logic [arpc_pkg::MAC_W-1:0]    out_mac_reg;
    logic                          out_send_reg;
    logic [arpc_pkg::IP_W-1:0]     out_target_reg;

    arpc_pkg::tag_req_t            tag_req;
    arpc_pkg::tag_t                tag_rdata;
    arpc_pkg::mac_req_t            mac_req;
    logic [arpc_pkg::MAC_W-1:0]    mac_rdata;

    logic                          s_accept;
    logic                          out_free;
    logic                          tag_hit;
    logic                          last_way;
    logic                          ignore_pkt;
    logic [arpc_pkg::WAY_W-1:0]    sel_way;
    logic                          sel_ok;

    arpc_store u_store (
        .aclk      (aclk),
        .tag_req   (tag_req),
        .tag_rdata (tag_rdata),
        .mac_req   (mac_req),
        .mac_rdata (mac_rdata)
    );

    // shared ip compare and scan status
    assign tag_hit    = tag_rdata.valid && (tag_rdata.ip == ip_reg);
    assign last_way   = (way_reg == arpc_pkg::WAY_W'(arpc_pkg::WAYS - 1));
    assign s_accept   = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign ignore_pkt = (s_tuser == arpc_pkg::CMD_PACKET)
                        && (s_tdata[95:80] != arpc_pkg::OP_REPLY);
    assign sel_way    = hit_reg ? hit_way_reg : free_way_reg;
    assign sel_ok     = hit_reg || free_found_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            arpc_pkg::S_CLEAR: begin
                if (clr_cnt_reg == arpc_pkg::TAG_AW'(arpc_pkg::TAG_DEPTH - 1)) begin
                    state_next = arpc_pkg::S_IDLE;
                end
            end
            arpc_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = ignore_pkt ? arpc_pkg::S_DONE : arpc_pkg::S_HASH;
                end
            end
            arpc_pkg::S_HASH: state_next = arpc_pkg::S_READ;
            arpc_pkg::S_READ: state_next = arpc_pkg::S_CMP;
            arpc_pkg::S_CMP: begin
                if (tag_hit || last_way) begin
                    state_next = arpc_pkg::S_UPDATE;
                end else begin
                    state_next = arpc_pkg::S_READ;
                end
            end
            arpc_pkg::S_UPDATE: state_next = arpc_pkg::S_DONE;
            arpc_pkg::S_DONE: begin
                if (out_free) begin
                    state_next = arpc_pkg::S_IDLE;
                end
            end
            default: state_next = arpc_pkg::S_CLEAR;
        endcase
    end

    // memory controls and handshake
    always_comb begin
        s_tready      = 1'b0;
        tag_req.we    = 1'b0;
        tag_req.waddr = {bucket_reg, sel_way};
        tag_req.wdata = '{resolved: (cmd_reg == arpc_pkg::CMD_PACKET),
                          valid: 1'b1, ip: ip_reg};
        tag_req.raddr = {bucket_reg, way_reg};
        mac_req.we    = 1'b0;
        mac_req.re    = 1'b0;
        mac_req.addr  = {bucket_reg, sel_way};
        mac_req.wdata = mac_in_reg;
        unique case (state_reg)
            arpc_pkg::S_CLEAR: begin
                tag_req.we    = 1'b1;
                tag_req.waddr = clr_cnt_reg;
                tag_req.wdata = '0;
            end
            arpc_pkg::S_IDLE: s_tready = 1'b1;
            arpc_pkg::S_UPDATE: begin
                mac_req.re = 1'b1;
                if (sel_ok) begin
                    if (cmd_reg == arpc_pkg::CMD_PACKET) begin
                        tag_req.we = 1'b1;
                        mac_req.we = 1'b1;
                    end else if (!hit_reg) begin
                        tag_req.we = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= arpc_pkg::S_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == arpc_pkg::S_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (state_reg == arpc_pkg::S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // item capture, scan and result datapath
    always_ff @(posedge aclk) begin
        // capture the item
        if (s_accept) begin
            cmd_reg        <= s_tuser;
            ip_reg         <= s_tdata[31:0];
            mac_in_reg     <= s_tdata[79:32];
            res_status_reg <= arpc_pkg::ST_IGNORED;
            res_mac_reg    <= 1'b0;
        end
        // bucket select and scan reset
        if (state_reg == arpc_pkg::S_HASH) begin
            bucket_reg     <= arpc_pkg::bucket_of(ip_reg);
            way_reg        <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        // one way per pass through the compare
        if (state_reg == arpc_pkg::S_CMP) begin
            if (tag_hit) begin
                hit_reg      <= 1'b1;
                hit_way_reg  <= way_reg;
                resolved_reg <= tag_rdata.resolved;
            end else if (!tag_rdata.valid && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_way_reg   <= way_reg;
            end
            if (!last_way) begin
                way_reg <= way_reg + 1'b1;
            end
        end
        // decide the result
        if (state_reg == arpc_pkg::S_UPDATE) begin
            res_mac_reg <= 1'b0;
            if (!sel_ok) begin
                res_status_reg <= arpc_pkg::ST_NOROOM;
            end else if (cmd_reg == arpc_pkg::CMD_PACKET) begin
                res_status_reg <= arpc_pkg::ST_DONE;
            end else if (hit_reg && resolved_reg) begin
                res_status_reg <= arpc_pkg::ST_DONE;
                res_mac_reg    <= 1'b1;
            end else begin
                res_status_reg <= arpc_pkg::ST_PENDING;
            end
        end
        // load the output register
        if (state_reg == arpc_pkg::S_DONE && out_free) begin
            out_status_reg <= res_status_reg;
            out_mac_reg    <= res_mac_reg ? mac_rdata : '0;
            out_send_reg   <= (res_status_reg == arpc_pkg::ST_PENDING);
            out_target_reg <= (res_status_reg == arpc_pkg::ST_PENDING) ? ip_reg : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'b0, out_target_reg, out_send_reg, out_mac_reg};

    // no item is taken during the clearing pass
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == arpc_pkg::S_CLEAR) |-> !s_tready)
        else $error("item accepted during tag clear");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("second item accepted while busy");

    // a request goes out exactly with a pending status
    a_send_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[48] == (m_tuser == arpc_pkg::ST_PENDING)))
        else $error("request flag disagrees with status");

    // a mac is returned only with done status
    a_mac_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != arpc_pkg::ST_DONE)) |-> (m_tdata[47:0] == '0))
        else $error("mac returned without resolved status");

endmodule
`default_nettype wire
